// ===== src/rvd_pkg.sv =====
// Shared types, constants and constant tables of the radial vertex dent block.
// Used by every module under src; depends on nothing.
package rvd_pkg;

  localparam int unsigned COUNT_BITS = 24;
  localparam int unsigned TOTAL_W    = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned EXP_STEPS  = 16;
  localparam int unsigned LOG_STEPS  = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POINT_X,
    CFG_POINT_Y,
    CFG_POINT_Z,
    CFG_NORMAL,
    CFG_RADIUS,
    CFG_DEPTH,
    CFG_FALLOFF
  } cfg_idx_e;

  typedef enum logic [1:0] {
    NRM_IDLE,
    NRM_ROOT,
    NRM_DIV
  } nrm_state_e;

  // Sideband that travels with a vertex through every stage.
  typedef struct packed {
    logic [2:0][31:0] v;
    logic [2:0][15:0] u;
    logic             hit;
    logic             last;
    logic [30:0]      max_depth;
    logic [15:0]      fexp;
  } side_t;

  // Status of the normal unit toward the top level.
  typedef struct packed {
    logic             busy;
    logic             nonzero;
    logic [2:0][15:0] u;
  } nrm_t;

  typedef logic [29:0] expc_t [EXP_STEPS];

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] bitv;
    logic [63:0] x;
    r    = '0;
    x    = v;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x = x - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  // Roots of one half: c(i) = 2^30 * 2^(-2^-(i+1)), rounded down step by step.
  function automatic expc_t build_expc();
    expc_t       t;
    logic [63:0] c;
    c = 64'd1 << 29;
    for (int i = 0; i < EXP_STEPS; i++) begin
      c    = isqrt64(c << 30);
      t[i] = c[29:0];
    end
    return t;
  endfunction

  localparam expc_t EXP_C = build_expc();

endpackage

// ===== src/rvd_normal_unit.sv =====
// Normal unit: turns the packed impact normal into a Q1.14 unit vector.
// Square root and three restoring dividers, one bit per cycle; uses rvd_pkg.
module rvd_normal_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [rvd_pkg::CFG_DATA_W-1:0]  npk_i,
  output rvd_pkg::nrm_t                   nrm_o
);
  import rvd_pkg::*;

  localparam logic [4:0] ROOT_LAST = 5'd15;
  localparam logic [4:0] DIV_LAST  = 5'd30;

  nrm_state_e       state_q, state_d;
  logic [4:0]       cnt_q, cnt_d;
  logic [2:0][15:0] a_q, a_d;
  logic [2:0]       neg_q, neg_d;
  logic [31:0]      s_q, s_d;
  logic             nz_q, nz_d;
  logic [18:0]      rem_q, rem_d;
  logic [15:0]      root_q, root_d;
  logic [2:0][30:0] num_q, num_d;
  logic [2:0][15:0] dr_q, dr_d;
  logic [2:0][14:0] dq_q, dq_d;
  logic [2:0][15:0] u_q, u_d;

  always_comb begin
    logic [15:0] n;
    logic [31:0] s;
    logic [18:0] rs;
    logic [18:0] trial;
    logic [16:0] ds;
    logic        ge;
    state_d = state_q;
    cnt_d   = cnt_q;
    a_d     = a_q;
    neg_d   = neg_q;
    s_d     = s_q;
    nz_d    = nz_q;
    rem_d   = rem_q;
    root_d  = root_q;
    num_d   = num_q;
    dr_d    = dr_q;
    dq_d    = dq_q;
    u_d     = u_q;
    if (start_i) begin
      s = '0;
      for (int k = 0; k < 3; k++) begin
        n        = npk_i[16*k +: 16];
        neg_d[k] = n[15];
        a_d[k]   = n[15] ? 16'(16'd0 - n) : n;
        s        = s + 32'(a_d[k]) * 32'(a_d[k]);
      end
      s_d     = s;
      nz_d    = (s != '0);
      rem_d   = '0;
      root_d  = '0;
      cnt_d   = '0;
      state_d = NRM_ROOT;
    end else begin
      case (state_q)
        NRM_IDLE: begin
        end
        NRM_ROOT: begin
          rs    = {rem_q[16:0], s_q[31:30]};
          trial = {1'b0, root_q, 2'b01};
          ge    = (rs >= trial);
          rem_d  = ge ? rs - trial : rs;
          root_d = {root_q[14:0], ge};
          s_d    = {s_q[29:0], 2'b00};
          cnt_d  = cnt_q + 5'd1;
          if (cnt_q == ROOT_LAST) begin
            for (int k = 0; k < 3; k++) begin
              num_d[k] = 31'({a_q[k], 14'd0}) + 31'(root_d[15:1]);
            end
            dr_d    = '0;
            dq_d    = '0;
            cnt_d   = '0;
            state_d = NRM_DIV;
          end
        end
        NRM_DIV: begin
          for (int k = 0; k < 3; k++) begin
            ds       = {dr_q[k], num_q[k][30]};
            ge       = (ds >= {1'b0, root_q});
            dr_d[k]  = ge ? 16'(ds - {1'b0, root_q}) : ds[15:0];
            dq_d[k]  = {dq_q[k][13:0], ge};
            num_d[k] = {num_q[k][29:0], 1'b0};
          end
          cnt_d = cnt_q + 5'd1;
          if (cnt_q == DIV_LAST) begin
            for (int k = 0; k < 3; k++) begin
              if (!nz_q) begin
                u_d[k] = '0;
              end else if (neg_q[k]) begin
                u_d[k] = 16'd0 - {1'b0, dq_d[k]};
              end else begin
                u_d[k] = {1'b0, dq_d[k]};
              end
            end
            state_d = NRM_IDLE;
          end
        end
        default: state_d = NRM_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= NRM_IDLE;
      cnt_q   <= '0;
      nz_q    <= 1'b0;
      u_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      nz_q    <= nz_d;
      u_q     <= u_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    neg_q  <= neg_d;
    s_q    <= s_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    num_q  <= num_d;
    dr_q   <= dr_d;
    dq_q   <= dq_d;
  end

  assign nrm_o.busy    = (state_q != NRM_IDLE);
  assign nrm_o.nonzero = nz_q;
  assign nrm_o.u       = u_q;

endmodule

// ===== src/rvd_radius_pipe.sv =====
// Radius pipeline: offset from the impact point, squared distance, square
// root and the normalized weight w = (r - d) / r in Q1.30; uses rvd_pkg.
module rvd_radius_pipe (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  rvd_pkg::side_t   side_i,
  input  logic [2:0][31:0] point_i,
  input  logic [30:0]      radius_i,
  output logic             valid_o,
  output rvd_pkg::side_t   side_o,
  output logic [30:0]      w_o
);
  import rvd_pkg::*;

  localparam int unsigned RT_STEPS = 32;
  localparam int unsigned DV_STEPS = 30;

  typedef struct packed {
    side_t            side;
    logic [30:0]      r;
    logic [2:0][30:0] adx;
  } ent_t;

  typedef struct packed {
    side_t            side;
    logic [30:0]      r;
    logic [2:0][61:0] sq;
    logic [61:0]      r2;
  } sqr_t;

  typedef struct packed {
    side_t       side;
    logic [30:0] r;
    logic [63:0] q;
    logic [34:0] rem;
    logic [31:0] root;
  } rt_t;

  typedef struct packed {
    side_t       side;
    logic [30:0] r;
    logic [31:0] rem;
    logic [30:0] w;
  } dv_t;

  ent_t ent_q, ent_d;
  sqr_t sqr_q, sqr_d;
  rt_t  rt_q [RT_STEPS+1];
  rt_t  rt0_d;
  rt_t  rt_nx [RT_STEPS];
  dv_t  dv_q [DV_STEPS+1];
  dv_t  dv0_d;
  dv_t  dv_nx [DV_STEPS];

  logic                ent_v_q, sqr_v_q;
  logic [RT_STEPS:0]   rt_v_q;
  logic [DV_STEPS:0]   dv_v_q;

  // Entry: axis offsets and the per-axis box test.
  always_comb begin
    logic signed [32:0] dx;
    logic [32:0]        adx;
    logic               in_box;
    in_box = 1'b1;
    for (int k = 0; k < 3; k++) begin
      dx  = $signed({side_i.v[k][31], side_i.v[k]}) -
            $signed({point_i[k][31], point_i[k]});
      adx = dx[32] ? 33'(-dx) : 33'(dx);
      if (adx >= {2'b00, radius_i}) in_box = 1'b0;
      ent_d.adx[k] = adx[30:0];
    end
    ent_d.side     = side_i;
    ent_d.side.hit = side_i.hit & in_box;
    ent_d.r        = radius_i;
  end

  always_comb begin
    sqr_d.side = ent_q.side;
    sqr_d.r    = ent_q.r;
    for (int k = 0; k < 3; k++) begin
      sqr_d.sq[k] = 62'(ent_q.adx[k]) * 62'(ent_q.adx[k]);
    end
    sqr_d.r2 = 62'(ent_q.r) * 62'(ent_q.r);
  end

  always_comb begin
    rt0_d.side     = sqr_q.side;
    rt0_d.r        = sqr_q.r;
    rt0_d.q        = 64'(sqr_q.sq[0]) + 64'(sqr_q.sq[1]) + 64'(sqr_q.sq[2]);
    rt0_d.side.hit = sqr_q.side.hit & (rt0_d.q < 64'(sqr_q.r2));
    rt0_d.rem      = '0;
    rt0_d.root     = '0;
  end

  // One root bit per stage, two radicand bits consumed each time.
  always_comb begin
    logic [34:0] rs;
    logic [34:0] trial;
    for (int j = 0; j < RT_STEPS; j++) begin
      rt_nx[j] = rt_q[j];
      rs       = {rt_q[j].rem[32:0], rt_q[j].q[2*(RT_STEPS-1-j) +: 2]};
      trial    = {1'b0, rt_q[j].root, 2'b01};
      if (rs >= trial) begin
        rt_nx[j].rem  = rs - trial;
        rt_nx[j].root = {rt_q[j].root[30:0], 1'b1};
      end else begin
        rt_nx[j].rem  = rs;
        rt_nx[j].root = {rt_q[j].root[30:0], 1'b0};
      end
    end
  end

  // Top quotient bit: for d <= r, r - d reaches r only at d = 0.
  always_comb begin
    logic [30:0] a;
    logic        top;
    a           = rt_q[RT_STEPS].r - rt_q[RT_STEPS].root[30:0];
    top         = (a >= rt_q[RT_STEPS].r);
    dv0_d.side  = rt_q[RT_STEPS].side;
    dv0_d.r     = rt_q[RT_STEPS].r;
    dv0_d.rem   = 32'(top ? a - rt_q[RT_STEPS].r : a);
    dv0_d.w     = 31'(top);
  end

  always_comb begin
    logic [31:0] rs;
    logic        ge;
    for (int j = 0; j < DV_STEPS; j++) begin
      dv_nx[j]     = dv_q[j];
      rs           = {dv_q[j].rem[30:0], 1'b0};
      ge           = (rs >= {1'b0, dv_q[j].r});
      dv_nx[j].rem = ge ? rs - {1'b0, dv_q[j].r} : rs;
      dv_nx[j].w   = {dv_q[j].w[29:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_v_q <= 1'b0;
      sqr_v_q <= 1'b0;
      rt_v_q  <= '0;
      dv_v_q  <= '0;
    end else if (en_i) begin
      ent_v_q <= valid_i;
      sqr_v_q <= ent_v_q;
      rt_v_q  <= {rt_v_q[RT_STEPS-1:0], sqr_v_q};
      dv_v_q  <= {dv_v_q[DV_STEPS-1:0], rt_v_q[RT_STEPS]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ent_q    <= ent_d;
      sqr_q    <= sqr_d;
      rt_q[0]  <= rt0_d;
      for (int j = 0; j < RT_STEPS; j++) rt_q[j+1] <= rt_nx[j];
      dv_q[0]  <= dv0_d;
      for (int j = 0; j < DV_STEPS; j++) dv_q[j+1] <= dv_nx[j];
    end
  end

  assign valid_o = dv_v_q[DV_STEPS];
  assign side_o  = dv_q[DV_STEPS].side;
  assign w_o     = dv_q[DV_STEPS].w;

endmodule

// ===== src/rvd_falloff_pipe.sv =====
// Falloff pipeline: F = w^e in Q1.30 as exp2(-e * -log2(w)).
// Log by repeated squaring, exp by a product of constant roots; uses rvd_pkg.
module rvd_falloff_pipe (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  rvd_pkg::side_t side_i,
  input  logic [30:0]    w_i,
  output logic           valid_o,
  output rvd_pkg::side_t side_o,
  output logic [30:0]    f_o
);
  import rvd_pkg::*;

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  typedef struct packed {
    side_t       side;
    logic        wz;
    logic [4:0]  sh;
    logic [30:0] m;
    logic [15:0] frac;
  } lg_t;

  typedef struct packed {
    side_t       side;
    logic        wz;
    logic [12:0] k;
    logic [15:0] f;
    logic [30:0] g;
  } ex_t;

  typedef struct packed {
    side_t       side;
    logic [30:0] f;
  } fo_t;

  lg_t lg_q [LOG_STEPS+1];
  lg_t lg0_d;
  lg_t lg_nx [LOG_STEPS];
  ex_t ex_q [EXP_STEPS+1];
  ex_t ex0_d;
  ex_t ex_nx [EXP_STEPS];
  fo_t fo_q, fo_d;

  logic [LOG_STEPS:0] lg_v_q;
  logic [EXP_STEPS:0] ex_v_q;
  logic               fo_v_q;

  // Normalize: leading one to bit 30.
  always_comb begin
    logic [4:0] p;
    p = '0;
    for (int b = 0; b < 31; b++) begin
      if (w_i[b]) p = 5'(b);
    end
    lg0_d.side = side_i;
    lg0_d.wz   = (w_i == '0);
    lg0_d.sh   = 5'd30 - p;
    lg0_d.m    = w_i << lg0_d.sh;
    lg0_d.frac = '0;
  end

  always_comb begin
    logic [61:0] prod;
    logic [31:0] mm;
    for (int j = 0; j < LOG_STEPS; j++) begin
      lg_nx[j] = lg_q[j];
      prod     = 62'(lg_q[j].m) * 62'(lg_q[j].m);
      mm       = prod[61:30];
      if (mm[31]) begin
        lg_nx[j].m    = mm[31:1];
        lg_nx[j].frac = {lg_q[j].frac[14:0], 1'b1};
      end else begin
        lg_nx[j].m    = mm[30:0];
        lg_nx[j].frac = {lg_q[j].frac[14:0], 1'b0};
      end
    end
  end

  // Scale the negated log by the exponent, split into shift and fraction.
  always_comb begin
    logic [20:0] nl;
    logic [36:0] prod;
    nl         = {lg_q[LOG_STEPS].sh, 16'd0} - {5'd0, lg_q[LOG_STEPS].frac};
    prod       = 37'(lg_q[LOG_STEPS].side.fexp) * 37'(nl);
    ex0_d.side = lg_q[LOG_STEPS].side;
    ex0_d.wz   = lg_q[LOG_STEPS].wz;
    ex0_d.k    = prod[36:24];
    ex0_d.f    = prod[23:8];
    ex0_d.g    = ONE_Q30;
  end

  always_comb begin
    logic [60:0] prod;
    for (int j = 0; j < EXP_STEPS; j++) begin
      ex_nx[j] = ex_q[j];
      prod     = 61'(ex_q[j].g) * 61'(EXP_C[j]);
      if (ex_q[j].f[EXP_STEPS-1-j]) ex_nx[j].g = prod[60:30];
    end
  end

  always_comb begin
    fo_d.side = ex_q[EXP_STEPS].side;
    if (ex_q[EXP_STEPS].side.fexp == '0) begin
      fo_d.f = ONE_Q30;
    end else if (ex_q[EXP_STEPS].wz || (ex_q[EXP_STEPS].k >= 13'd31)) begin
      fo_d.f = '0;
    end else begin
      fo_d.f = ex_q[EXP_STEPS].g >> ex_q[EXP_STEPS].k[4:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lg_v_q <= '0;
      ex_v_q <= '0;
      fo_v_q <= 1'b0;
    end else if (en_i) begin
      lg_v_q <= {lg_v_q[LOG_STEPS-1:0], valid_i};
      ex_v_q <= {ex_v_q[EXP_STEPS-1:0], lg_v_q[LOG_STEPS]};
      fo_v_q <= ex_v_q[EXP_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lg_q[0] <= lg0_d;
      for (int j = 0; j < LOG_STEPS; j++) lg_q[j+1] <= lg_nx[j];
      ex_q[0] <= ex0_d;
      for (int j = 0; j < EXP_STEPS; j++) ex_q[j+1] <= ex_nx[j];
      fo_q    <= fo_d;
    end
  end

  assign valid_o = fo_v_q;
  assign side_o  = fo_q.side;
  assign f_o     = fo_q.f;

endmodule

// ===== src/radial_vertex_dent.sv =====
// Top level of the radial vertex dent block: register file, mesh tracking,
// depth and offset stages and the output register; uses rvd_pkg and all units.
//
// Vertices stream in on the slave side and come out in order on the master
// side, one result per vertex, one vertex per cycle sustained while the
// master side takes results and the normal unit is idle. A vertex passes
// 104 register stages: 2 for the axis offsets and squares, 33 for the sum
// and the bit-serial square root, 31 for the weight divider, 35 for the
// log/exp chain of the falloff and 3 for depth, offset and the output
// register. A stall on the master side freezes the whole pipeline in place.
// Writing the normal register starts the normal unit, a square root and
// divide sequence; s_tready_o stays low until it is done. The unit
// normal and the active flag are taken on the first vertex of each mesh and
// hold until the vertex with tlast; point, radius, depth and exponent are
// sampled per vertex. The displaced count saturates and clears after the
// last vertex. There is no clearing pass after reset.
module radial_vertex_dent (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [rvd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rvd_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  // vertex stream in
  input  logic                            s_tvalid_i,
  output logic                            s_tready_o,
  input  logic [95:0]                     s_tdata_i,  // vertex_x, vertex_y, vertex_z
  input  logic                            s_tlast_i,  // last_vertex
  // vertex stream out
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  output logic [119:0]                    m_tdata_o,  // moved_x, moved_y, moved_z, moved_total
  output logic                            m_tuser_o,  // was_moved
  output logic                            m_tlast_o   // is_last
);
  import rvd_pkg::*;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  typedef struct packed {
    side_t       side;
    logic [30:0] depth;
  } dp_t;

  typedef struct packed {
    side_t            side;
    logic [30:0]      depth;
    logic [2:0][32:0] off;
  } of_t;

  typedef struct packed {
    logic [2:0][31:0]     xyz;
    logic                 moved;
    logic [TOTAL_W-1:0]   total;
    logic                 last;
  } out_t;

  // configuration registers
  logic [2:0][31:0] point_q;
  logic [30:0]      radius_q;
  logic [30:0]      maxd_q;
  logic [15:0]      fexp_q;

  // mesh state
  logic             open_q;
  logic [2:0][15:0] un_q;
  logic             act_q;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;

  nrm_t   nrm;
  logic   en;
  logic   accept;
  logic   first;
  side_t  side_in;

  logic   rp_v;
  side_t  rp_side;
  logic [30:0] rp_w;
  logic   fp_v;
  side_t  fp_side;
  logic [30:0] fp_f;

  logic   dp_v_q, of_v_q, out_v_q;
  dp_t    dp_q, dp_d;
  of_t    of_q, of_d;
  out_t   out_q, out_d;

  // Advance everything whenever the output register is free or drains.
  assign en         = !out_v_q || m_tready_i;
  assign s_tready_o = en && !nrm.busy;
  assign accept     = s_tvalid_i && s_tready_o;
  assign first      = !open_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_q  <= '0;
      radius_q <= '0;
      maxd_q   <= '0;
      fexp_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_POINT_X: point_q[0] <= cfg_wdata_i[31:0];
        CFG_POINT_Y: point_q[1] <= cfg_wdata_i[31:0];
        CFG_POINT_Z: point_q[2] <= cfg_wdata_i[31:0];
        CFG_RADIUS:  radius_q   <= cfg_wdata_i[30:0];
        CFG_DEPTH:   maxd_q     <= cfg_wdata_i[30:0];
        CFG_FALLOFF: fexp_q     <= cfg_wdata_i[15:0];
        default: begin
        end
      endcase
    end
  end

  rvd_normal_unit u_normal (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cfg_we_i && (cfg_idx_i == CFG_NORMAL)),
    .npk_i   (cfg_wdata_i),
    .nrm_o   (nrm)
  );

  // Take the normal and the active flag on the first vertex of a mesh.
  always_comb begin
    side_in.v         = s_tdata_i;
    side_in.u         = first ? nrm.u : un_q;
    side_in.hit       = first ? ((radius_q != '0) && (maxd_q != '0) && nrm.nonzero)
                              : act_q;
    side_in.last      = s_tlast_i;
    side_in.max_depth = maxd_q;
    side_in.fexp      = fexp_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      un_q   <= '0;
      act_q  <= 1'b0;
    end else if (accept) begin
      if (first) begin
        un_q  <= side_in.u;
        act_q <= side_in.hit;
      end
      open_q <= !s_tlast_i;
    end
  end

  rvd_radius_pipe u_radius (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (accept),
    .side_i   (side_in),
    .point_i  (point_q),
    .radius_i (radius_q),
    .valid_o  (rp_v),
    .side_o   (rp_side),
    .w_o      (rp_w)
  );

  rvd_falloff_pipe u_falloff (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rp_v),
    .side_i  (rp_side),
    .w_i     (rp_w),
    .valid_o (fp_v),
    .side_o  (fp_side),
    .f_o     (fp_f)
  );

  // Depth never exceeds max_depth since F is at most one.
  always_comb begin
    logic [61:0] prod;
    prod       = 62'(fp_side.max_depth) * 62'(fp_f);
    dp_d.side  = fp_side;
    dp_d.depth = prod[60:30];
  end

  // Per-axis offset, magnitude rounded to nearest.
  always_comb begin
    logic [15:0] au;
    logic [46:0] prod;
    of_d.side  = dp_q.side;
    of_d.depth = dp_q.depth;
    for (int k = 0; k < 3; k++) begin
      au          = dp_q.side.u[k][15] ? 16'(16'd0 - dp_q.side.u[k]) : dp_q.side.u[k];
      prod        = 47'(au) * 47'(dp_q.depth) + 47'd8192;
      of_d.off[k] = prod[46:14];
    end
  end

  // Apply the offset against the normal, saturate, count displaced vertices.
  always_comb begin
    logic signed [33:0] r;
    logic               moved;
    moved = of_q.side.hit && (of_q.depth != '0);
    for (int k = 0; k < 3; k++) begin
      if (of_q.side.u[k][15]) begin
        r = $signed({{2{of_q.side.v[k][31]}}, of_q.side.v[k]}) + $signed({1'b0, of_q.off[k]});
      end else begin
        r = $signed({{2{of_q.side.v[k][31]}}, of_q.side.v[k]}) - $signed({1'b0, of_q.off[k]});
      end
      if (!moved) begin
        out_d.xyz[k] = of_q.side.v[k];
      end else if (r > 34'sd2147483647) begin
        out_d.xyz[k] = 32'h7FFF_FFFF;
      end else if (r < -34'sd2147483648) begin
        out_d.xyz[k] = 32'h8000_0000;
      end else begin
        out_d.xyz[k] = r[31:0];
      end
    end
    cnt_d       = (moved && (cnt_q != CNT_MAX)) ? cnt_q + CNT_ONE : cnt_q;
    out_d.moved = moved;
    out_d.total = TOTAL_W'(cnt_d);
    out_d.last  = of_q.side.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dp_v_q  <= 1'b0;
      of_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      cnt_q   <= '0;
    end else if (en) begin
      dp_v_q  <= fp_v;
      of_v_q  <= dp_v_q;
      out_v_q <= of_v_q;
      if (of_v_q) begin
        cnt_q <= of_q.side.last ? '0 : cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dp_q  <= dp_d;
      of_q  <= of_d;
      out_q <= out_d;
    end
  end

  assign m_tvalid_o = out_v_q;
  assign m_tdata_o  = {out_q.total, out_q.xyz};
  assign m_tuser_o  = out_q.moved;
  assign m_tlast_o  = out_q.last;

`ifndef NO_ASSERTIONS
  // A displaced vertex is always part of the count it reports.
  a_moved_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tuser_o) |-> (m_tdata_o[119:96] != '0))
    else $error("displaced vertex reports a zero count");

  // No vertex enters while the normal unit is still working.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nrm.busy |-> !(s_tvalid_i && s_tready_o))
    else $error("vertex accepted while normal unit busy");

  // The mesh closes on the transfer of its last vertex.
  a_mesh_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o && s_tlast_i) |=> !open_q)
    else $error("mesh still open after last vertex");
`endif

endmodule
